// File: rtl/msdb_pkg.sv
// shared types and constants of the multi-switch debouncer
`default_nettype none
package msdb_pkg;

  localparam int PIN_W            = 8;
  localparam int IDX_W            = 3;
  localparam int READ_SLOTS       = 2 ** IDX_W;
  localparam int CNT_W            = 4;
  localparam int CFG_IDX_W        = 1;
  localparam int CFG_DATA_W       = 8;
  localparam int NUM_SWITCHES_DEF = 8;

  localparam logic [CNT_W-1:0] STABLE_COUNT_RST = CNT_W'(5);

  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_LEVELS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_STABLE_COUNT  = 1'b1;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef enum logic [1:0] {
    ST_NOT_PRESSED = 2'd0,
    ST_PRESSED     = 2'd1,
    ST_RELEASED    = 2'd2
  } status_t;

  typedef struct packed {
    logic tick;
    logic rd_clear;
  } lane_ctl_t;

endpackage
`default_nettype wire

// File: rtl/msdb_lane.sv
// one switch lane: stability counter and debounced state
`default_nettype none
module msdb_lane (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire msdb_pkg::lane_ctl_t        ctl,
  input  wire logic                       level,
  input  wire logic                       active,
  input  wire logic [msdb_pkg::CNT_W-1:0] stable_count,
  output msdb_pkg::status_t               state
);
  import msdb_pkg::*;

  logic              prev_r, prev_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt, cnt_inc;
  status_t           state_r, state_nxt;
  logic              pressed;

  assign pressed = level ^ active;
  assign cnt_inc = (level == prev_r) ? cnt_r + CNT_W'(1) : '0;

  always_comb begin
    prev_nxt  = prev_r;
    cnt_nxt   = cnt_r;
    state_nxt = state_r;
    if (ctl.tick) begin
      prev_nxt = level;
      cnt_nxt  = cnt_inc;
      if (cnt_inc == stable_count) begin
        cnt_nxt = '0;
        case (state_r)
          ST_PRESSED:  state_nxt = pressed ? ST_PRESSED : ST_RELEASED;
          ST_RELEASED: state_nxt = ST_RELEASED;
          default:     state_nxt = pressed ? ST_PRESSED : ST_NOT_PRESSED;
        endcase
      end
    end else if (ctl.rd_clear && state_r == ST_RELEASED) begin
      state_nxt = ST_NOT_PRESSED;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r  <= 1'b0;
      cnt_r   <= '0;
      state_r <= ST_NOT_PRESSED;
    end else begin
      prev_r  <= prev_nxt;
      cnt_r   <= cnt_nxt;
      state_r <= state_nxt;
    end
  end

  assign state = state_r;

endmodule
`default_nettype wire

// File: rtl/msdb_merge.sv
// read select over all lanes and the registered result item
`default_nettype none
module msdb_merge #(
  parameter int NUM_SWITCHES = msdb_pkg::NUM_SWITCHES_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       rd_accept,
  input  wire logic [msdb_pkg::IDX_W-1:0] rd_index,
  input  wire msdb_pkg::status_t          lane_state [NUM_SWITCHES],
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [1:0]                      out_switch_status
);
  import msdb_pkg::*;

  status_t slot_state [READ_SLOTS];
  logic    valid_r, valid_nxt;
  status_t status_r, status_nxt;

  for (genvar s = 0; s < READ_SLOTS; s++) begin : g_slot
    if (s < NUM_SWITCHES) begin : g_hit
      assign slot_state[s] = lane_state[s];
    end else begin : g_miss
      assign slot_state[s] = ST_NOT_PRESSED;
    end
  end

  always_comb begin
    valid_nxt  = valid_r;
    status_nxt = status_r;
    if (valid_r && out_ready) valid_nxt = 1'b0;
    if (rd_accept) begin
      valid_nxt  = 1'b1;
      status_nxt = slot_state[rd_index];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
  end

  assign out_valid         = valid_r;
  assign out_switch_status = status_r;

endmodule
`default_nettype wire

// File: rtl/multi_switch_debouncer.sv
// top level of the multi-switch debouncer
`default_nettype none
// Debounces NUM_SWITCHES switches, one lane per switch working in parallel.
// A tick item (op 0) samples all pins and yields no result; a read item
// (op 1) returns the state of one switch in the cycle after it is taken,
// through an output register, clearing a released state to not pressed.
// One item is taken every cycle while the output register is empty or being
// drained; ready drops only while a result is held and out_ready is low.
// Switches 8 and up see pin and active level 0 and cannot be read; reads
// of a switch at or above NUM_SWITCHES return not pressed. Configuration:
// index 0 is active_levels, index 1 is stable_count (low 4 bits of cfg_data).
module multi_switch_debouncer #(
  parameter int NUM_SWITCHES = msdb_pkg::NUM_SWITCHES_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [msdb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [msdb_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic                            in_op,
  input  wire logic [msdb_pkg::PIN_W-1:0]      in_pin_levels,
  input  wire logic [msdb_pkg::IDX_W-1:0]      in_switch_index,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [1:0]                           out_switch_status
);
  import msdb_pkg::*;

  logic [PIN_W-1:0] active_levels_r;
  logic [CNT_W-1:0] stable_count_r;
  logic             in_accept;
  status_t          lane_state [NUM_SWITCHES];

  assign in_ready  = !out_valid || out_ready;
  assign in_accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_levels_r <= '0;
      stable_count_r  <= STABLE_COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ACTIVE_LEVELS: active_levels_r <= cfg_data[PIN_W-1:0];
        CFG_STABLE_COUNT:  stable_count_r  <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  for (genvar s = 0; s < NUM_SWITCHES; s++) begin : g_lane
    lane_ctl_t ctl;
    logic      level;
    logic      active;

    if (s < PIN_W) begin : g_pin
      assign level  = in_pin_levels[s];
      assign active = active_levels_r[s];
    end else begin : g_nopin
      assign level  = 1'b0;
      assign active = 1'b0;
    end

    if (s < READ_SLOTS) begin : g_rd
      assign ctl.rd_clear = in_accept && (in_op == OP_READ) &&
                            (in_switch_index == IDX_W'(s));
    end else begin : g_nord
      assign ctl.rd_clear = 1'b0;
    end
    assign ctl.tick = in_accept && (in_op == OP_TICK);

    msdb_lane u_lane (
      .clk          (clk),
      .rst_n        (rst_n),
      .ctl          (ctl),
      .level        (level),
      .active       (active),
      .stable_count (stable_count_r),
      .state        (lane_state[s])
    );
  end

  msdb_merge #(
    .NUM_SWITCHES (NUM_SWITCHES)
  ) u_merge (
    .clk               (clk),
    .rst_n             (rst_n),
    .rd_accept         (in_accept && (in_op == OP_READ)),
    .rd_index          (in_switch_index),
    .lane_state        (lane_state),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_switch_status (out_switch_status)
  );

endmodule
`default_nettype wire
